// ===== rtl/rcoct_pkg.sv =====
package rcoct_pkg;

  localparam int unsigned TableEntriesDef = 16;

  typedef enum logic [1:0] {
    CMD_INC   = 2'd0,
    CMD_SET   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_FLUSH = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_FLUSH = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [31:0]        block;
    logic signed [31:0] amount;
    logic [31:0]        base_count;
  } req_t;

  typedef struct packed {
    kind_e              kind;
    status_e            status;
    logic [31:0]        out_block;
    logic               is_set;
    logic signed [31:0] out_amount;
    logic [31:0]        adjusted_count;
    logic               above_one;
    logic               reserved;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic               valid;
    logic [31:0]        block;
    logic               is_set;
    logic signed [31:0] amount;
    logic               reserved;
  } entry_t;

  typedef struct packed {
    logic               cmp;
    logic               upd;
    logic               shift;
    logic               hit;
    logic [31:0]        block;
    logic signed [31:0] amount;
    logic               is_set;
    logic               positive;
  } cell_ctl_t;

endpackage

// ===== rtl/rcoct_cell.sv =====
module rcoct_cell
  import rcoct_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  logic      prev_valid_i,
  input  entry_t    nxt_i,
  output entry_t    entry_o,
  output logic      match_o
);

  logic               valid_q, valid_d;
  logic [31:0]        block_q, block_d;
  logic               is_set_q, is_set_d;
  logic signed [31:0] amount_q, amount_d;
  logic               reserved_q, reserved_d;
  logic               match_q, match_d;

  always_comb begin
    valid_d    = valid_q;
    block_d    = block_q;
    is_set_d   = is_set_q;
    amount_d   = amount_q;
    reserved_d = reserved_q;
    match_d    = match_q;
    if (ctl_i.cmp) begin
      match_d = valid_q && (block_q == ctl_i.block);
    end
    if (ctl_i.shift) begin
      valid_d    = nxt_i.valid;
      block_d    = nxt_i.block;
      is_set_d   = nxt_i.is_set;
      amount_d   = nxt_i.amount;
      reserved_d = nxt_i.reserved;
    end else if (ctl_i.upd) begin
      if (match_q) begin
        if (ctl_i.is_set) begin
          is_set_d = 1'b1;
          amount_d = ctl_i.amount;
        end else begin
          amount_d = amount_q + ctl_i.amount;
        end
        reserved_d = reserved_q | ctl_i.positive;
      end else if (!ctl_i.hit && !valid_q && prev_valid_i) begin
        valid_d    = 1'b1;
        block_d    = ctl_i.block;
        is_set_d   = ctl_i.is_set;
        amount_d   = ctl_i.amount;
        reserved_d = ctl_i.positive;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    block_q    <= block_d;
    is_set_q   <= is_set_d;
    amount_q   <= amount_d;
    reserved_q <= reserved_d;
    match_q    <= match_d;
  end

  assign entry_o = '{valid: valid_q, block: block_q, is_set: is_set_q,
                     amount: amount_q, reserved: reserved_q};
  assign match_o = match_q;

endmodule

// ===== rtl/refcount_op_coalescing_table.sv =====
// Deferred reference-count update table built as a row of TableEntries cells, one entry each.
// An item is taken when start_i is high and busy_o is low. Increment, set and query pass
// through a compare state, where every cell compares its block, then an execute state, where
// the matching cell merges or answers (on an update miss the first free cell takes it). A flush
// emits one result per stored entry (a single result when the table is empty): the row shifts
// toward cell 0 and cell 0 is emitted in each cycle. Each result appears on rsp_o for exactly
// one cycle with rsp_valid_o high; the receiver cannot stall, so it must take every result in
// that cycle. The next item may start in the cycle its predecessor's final result is shown.
module refcount_op_coalescing_table
  import rcoct_pkg::*;
#(
  parameter int unsigned TableEntries = TableEntriesDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CMP   = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0] state_q, state_d;
  req_t       req_q;
  rsp_t       rsp_q, rsp_d;
  logic       rsp_valid_q, rsp_valid_d;
  logic       accept;

  cell_ctl_t              ctl;
  entry_t                 ent [TableEntries];
  logic [TableEntries-1:0] match;
  logic [TableEntries-1:0] vld;
  logic                   hit;
  entry_t                 sel;
  logic                   nxt_valid0;
  logic [31:0]            one_plus;

  assign accept = start_i && !busy_o;

  for (genvar i = 0; i < TableEntries; i++) begin : g_cell
    entry_t nxt;
    logic   prev_valid;
    if (i == TableEntries - 1) begin : g_end
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = ent[i+1];
    end
    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_rest
      assign prev_valid = ent[i-1].valid;
    end
    rcoct_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .prev_valid_i(prev_valid),
      .nxt_i       (nxt),
      .entry_o     (ent[i]),
      .match_o     (match[i])
    );
    assign vld[i] = ent[i].valid;
  end

  if (TableEntries > 1) begin : g_nxt
    assign nxt_valid0 = ent[1].valid;
  end else begin : g_single
    assign nxt_valid0 = 1'b0;
  end

  assign hit = |match;

  always_comb begin
    sel = '0;
    for (int i = 0; i < TableEntries; i++) begin
      if (match[i]) begin
        sel = sel | ent[i];
      end
    end
  end

  assign one_plus = 32'd1 + 32'(sel.amount);

  always_comb begin
    ctl          = '0;
    ctl.block    = req_q.block;
    ctl.amount   = req_q.amount;
    ctl.is_set   = (req_q.cmd == CMD_SET);
    ctl.positive = !req_q.amount[31] && (req_q.amount != '0);
    ctl.hit      = hit;
    state_d      = state_q;
    rsp_d        = '0;
    rsp_valid_d  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (req_i.cmd == CMD_FLUSH) ? ST_FLUSH : ST_CMP;
        end
      end
      ST_CMP: begin
        ctl.cmp = 1'b1;
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        rsp_valid_d = 1'b1;
        rsp_d.last  = 1'b1;
        state_d     = ST_IDLE;
        if (req_q.cmd == CMD_QUERY) begin
          rsp_d.kind = KIND_QUERY;
          if (!hit) begin
            rsp_d.adjusted_count = req_q.base_count;
          end else if (sel.is_set) begin
            rsp_d.adjusted_count = 32'(sel.amount);
            rsp_d.above_one      = 32'(sel.amount) > 32'd1;
            rsp_d.reserved       = sel.reserved;
          end else begin
            rsp_d.adjusted_count = req_q.base_count + 32'(sel.amount);
            rsp_d.above_one      = one_plus > 32'd1;
            rsp_d.reserved       = sel.reserved;
          end
        end else begin
          ctl.upd    = 1'b1;
          rsp_d.kind = KIND_ACK;
          if (!hit && vld[TableEntries-1]) begin
            rsp_d.status = STATUS_FULL;
          end
        end
      end
      ST_FLUSH: begin
        rsp_valid_d = 1'b1;
        rsp_d.kind  = KIND_FLUSH;
        if (ent[0].valid) begin
          ctl.shift        = 1'b1;
          rsp_d.out_block  = ent[0].block;
          rsp_d.is_set     = ent[0].is_set;
          rsp_d.out_amount = ent[0].amount;
          rsp_d.last       = !nxt_valid0;
          if (!nxt_valid0) begin
            state_d = ST_IDLE;
          end
        end else begin
          rsp_d.status = STATUS_EMPTY;
          rsp_d.last   = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (accept) begin
      req_q <= req_i;
    end
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // occupied cells always form a prefix of the row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((vld >> 1) & ~vld) == '0)
    else $error("gap in occupied cells");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |-> $onehot0(match))
    else $error("block held by more than one cell");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.cmd != CMD_FLUSH) |=> ##2 (rsp_valid_o && rsp_o.last))
    else $error("update or query result missing");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_o.last) |-> (rsp_o.kind == KIND_FLUSH))
    else $error("multiple results outside a flush");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status == STATUS_FULL) |-> $past(vld[TableEntries-1]))
    else $error("drop reported with free cell");

endmodule
